[hw/rtl/urlc_pkg.sv]
// shared types, codes and the response word classifier for the line classifier
package urlc_pkg;

    localparam logic [1:0] KIND_BYTE    = 2'd0;
    localparam logic [1:0] KIND_TIMEOUT = 2'd1;
    localparam logic [1:0] KIND_DISCARD = 2'd2;

    localparam logic [2:0] ST_STORED    = 3'd0;
    localparam logic [2:0] ST_DONE      = 3'd1;
    localparam logic [2:0] ST_PROTO_ERR = 3'd2;
    localparam logic [2:0] ST_TOO_SMALL = 3'd3;
    localparam logic [2:0] ST_DISCARD   = 3'd4;

    localparam logic [3:0] CLS_UNKNOWN   = 4'd0;
    localparam logic [3:0] CLS_DATA      = 4'd1;
    localparam logic [3:0] CLS_OK        = 4'd2;
    localparam logic [3:0] CLS_ERROR     = 4'd3;
    localparam logic [3:0] CLS_OVERVOLT  = 4'd4;
    localparam logic [3:0] CLS_UNDERVOLT = 4'd5;
    localparam logic [3:0] CLS_RESET     = 4'd6;
    localparam logic [3:0] CLS_READY     = 4'd7;
    localparam logic [3:0] CLS_SLEEP     = 4'd8;
    localparam logic [3:0] CLS_WAKE      = 4'd9;
    localparam logic [3:0] CLS_DONE      = 4'd10;

    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_STAR = 8'h2A;

    localparam int         CAP_W       = 7;
    localparam logic [6:0] CAP_RESET   = 7'd64;
    localparam int         HEAD_LEN    = 5;
    localparam logic       REG_LINE_CAP = 1'b0;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] rx_byte;
    } t_in_word;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] data_byte;
        logic [5:0] byte_index;
        logic [5:0] line_length;
        logic [3:0] response_class;
        logic       is_control;
        logic       is_terminal;
        logic [3:0] last_class;
    } t_out_word;

    function automatic logic [3:0] classify(input logic [HEAD_LEN-1:0][7:0] head,
                                            input logic is_len3,
                                            input logic is_len5);
        logic [3:0] cls;
        cls = CLS_DATA;
        if (is_len5 && head[0] == CH_STAR && head[1] == "D" && head[2] == "O"
                && head[3] == "N" && head[4] == "E") begin
            cls = CLS_DONE;
        end else if (is_len3 && head[0] == CH_STAR) begin
            case ({head[1], head[2]})
                "OK":    cls = CLS_OK;
                "ER":    cls = CLS_ERROR;
                "OV":    cls = CLS_OVERVOLT;
                "UV":    cls = CLS_UNDERVOLT;
                "RS":    cls = CLS_RESET;
                "RE":    cls = CLS_READY;
                "SL":    cls = CLS_SLEEP;
                "WA":    cls = CLS_WAKE;
                default: cls = CLS_DATA;
            endcase
        end
        return cls;
    endfunction

endpackage

[hw/rtl/urlc_line_core.sv]
// line state, head characters and per-word result logic
module urlc_line_core
    import urlc_pkg::*;
#(
    parameter int MAX_LINE = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  t_in_word         i_item,
    input  logic [CAP_W-1:0] i_cap,
    output t_out_word        o_result
);

    localparam int FW = $clog2(MAX_LINE);
    localparam int CW = (FW + 1 > CAP_W) ? FW + 1 : CAP_W;

    logic [FW-1:0]                r_fill;
    logic [FW-1:0]                n_fill;
    logic [HEAD_LEN-1:0][7:0]     r_head;
    logic [HEAD_LEN-1:0][7:0]     n_head;
    logic [3:0]                   r_held;
    logic [3:0]                   n_held;
    logic [CW-1:0]                cap_ext;
    logic [CW-1:0]                cap_eff;
    logic [3:0]                   cls;
    logic                         fill_zero;

    always_comb begin
        cap_ext = CW'(i_cap);
        cap_eff = cap_ext;
        if (cap_ext > CW'(MAX_LINE)) begin
            cap_eff = CW'(MAX_LINE);
        end
        if (cap_ext == '0) begin
            cap_eff = CW'(1);
        end
    end

    assign fill_zero = (r_fill == '0);

    always_comb begin
        n_fill   = r_fill;
        n_head   = r_head;
        n_held   = r_held;
        o_result = '0;
        cls      = CLS_UNKNOWN;
        if ((i_item.kind == KIND_BYTE || i_item.kind == KIND_TIMEOUT) && fill_zero) begin
            n_held = CLS_UNKNOWN;
        end
        case (i_item.kind)
            KIND_BYTE: begin
                if (i_item.rx_byte == CH_CR) begin
                    if (fill_zero) begin
                        o_result.status = ST_PROTO_ERR;
                    end else begin
                        cls                  = classify(r_head, r_fill == FW'(3),
                                                        r_fill == FW'(5));
                        o_result.status      = ST_DONE;
                        o_result.line_length = 6'(r_fill);
                        n_held               = cls;
                        n_fill               = '0;
                    end
                end else if (CW'(r_fill) + CW'(1) >= cap_eff) begin
                    o_result.status = ST_TOO_SMALL;
                    n_fill          = '0;
                    n_held          = CLS_UNKNOWN;
                end else begin
                    o_result.status     = ST_STORED;
                    o_result.data_byte  = i_item.rx_byte;
                    o_result.byte_index = 6'(r_fill);
                    for (int i = 0; i < HEAD_LEN; i++) begin
                        if (r_fill == FW'(i)) begin
                            n_head[i] = i_item.rx_byte;
                        end
                    end
                    n_fill = r_fill + FW'(1);
                end
            end
            KIND_TIMEOUT: begin
                o_result.status = ST_PROTO_ERR;
                n_fill          = '0;
                n_held          = CLS_UNKNOWN;
            end
            default: begin
                o_result.status = ST_DISCARD;
                n_fill          = '0;
                n_held          = CLS_UNKNOWN;
            end
        endcase
        o_result.response_class = cls;
        o_result.is_control     = (cls >= CLS_OK);
        o_result.is_terminal    = (cls == CLS_OK || cls == CLS_ERROR || cls == CLS_DONE);
        o_result.last_class     = n_held;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_held <= CLS_UNKNOWN;
        end else if (i_advance) begin
            r_fill <= n_fill;
            r_held <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_head <= n_head;
        end
    end

`ifndef ASSERT_OFF
    a_fill_below_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < FW'(MAX_LINE - 1) || r_fill == FW'(MAX_LINE - 1))
        else $error("line fill count beyond buffer size");

    a_done_clears_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && o_result.status == ST_DONE |=> r_fill == '0)
        else $error("fill count not cleared after completed line");

    a_store_counts_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && o_result.status == ST_STORED |=> r_fill == $past(r_fill) + FW'(1))
        else $error("stored byte did not advance fill count");
`endif

endmodule

[hw/rtl/uart_response_line_classifier_unit.sv]
// top level of the response line classifier with input and result registers
// channels: input word (kind, rx_byte) and result word, both valid/ready;
//   one result word for every input word, in order
// configuration: apb-style port, line_capacity at byte address 0, reads back
// datapath: a word accepted into the input register is classified and
//   registered in the result register when it leaves the input register
// throughput: one word per cycle unless the receiver stalls; input and result
//   registers let a new word enter while a finished result waits to be taken
// receiver stall: the result register holds, the input register fills, then
//   input ready drops until the result is taken
// reset: no line in progress, held class unknown, line_capacity 64, both
//   registers empty
module uart_response_line_classifier_unit
    import urlc_pkg::*;
#(
    parameter int MAX_LINE = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word,
    input  logic      psel,
    input  logic      penable,
    input  logic      pwrite,
    input  logic [2:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic      pready
);

    logic             r_in_valid;
    t_in_word         r_in_word;
    logic             r_out_valid;
    t_out_word        r_out_word;
    logic [CAP_W-1:0] r_cap;
    logic             advance;
    logic             cap_write;
    t_out_word        result;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign cap_write  = psel && penable && pwrite && (paddr[2] == REG_LINE_CAP);

    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == REG_LINE_CAP) ? 32'(r_cap) : '0;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (cap_write) begin
            r_cap <= pwdata[CAP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_in_word;
        end
        if (advance) begin
            r_out_word <= result;
        end
    end

    urlc_line_core #(
        .MAX_LINE (MAX_LINE)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in_word),
        .i_cap     (r_cap),
        .o_result  (result)
    );

`ifndef ASSERT_OFF
    a_advance_loads_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("classified word not loaded into result register");

    a_stall_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_in_valid && r_out_valid && !i_out_ready)
        else $error("input stalled while a register is free");

    a_cap_only_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !cap_write |=> $stable(r_cap))
        else $error("line capacity changed without a write");
`endif

endmodule
